### rtl/ohtu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohtu_pkg
// Shared types, codes and defaults of the open-addressing hash table unit.
// ----------------------------------------------------------------------------
package ohtu_pkg;

    // Defaults of the top-level parameters
    localparam int DEF_SLOTS      = 1024;
    localparam int DEF_VALUE_BITS = 32;

    // Fixed field widths
    localparam int FUNC_W   = 3;
    localparam int KEY_W    = 21;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = 11;
    localparam int STATUS_W = 3;
    localparam int TAG_W    = 2;

    localparam logic [IDX_W-1:0] LOAD_LIMIT_RST = 11'd820;

    // Request function codes
    localparam logic [FUNC_W-1:0] FUNC_GET   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SCAN  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

    // Slot tags
    localparam logic [TAG_W-1:0] TAG_EMPTY = 2'd0;
    localparam logic [TAG_W-1:0] TAG_LIVE  = 2'd1;
    localparam logic [TAG_W-1:0] TAG_TOMB  = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] value;
        logic [IDX_W-1:0]  scan_from;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   found_value;
        logic [KEY_W-1:0]    found_key;
        logic [IDX_W-1:0]    next_scan;
        logic [IDX_W-1:0]    live_count;
    } t_result;

endpackage

### rtl/ohtu_slot_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohtu_slot_mem
// Slot storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ohtu_slot_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 55
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write slot, read slot for the next cycle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/ohtu_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohtu_engine
// Probe sequencer: walks slots one read per cycle through a shared address
// adder, resolves get/set/pop/scan/clear and keeps the slot counts.
// ----------------------------------------------------------------------------
module ohtu_engine import ohtu_pkg::*; #(
    parameter int SLOTS      = DEF_SLOTS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_req             i_req,
    input  logic [IDX_W-1:0] i_load_limit,
    output logic             o_idle,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output t_result          o_res
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = IW + 1;
    localparam int MW = TAG_W + KEY_W + VALUE_BITS;
    localparam logic [31:0] SLOTS_W = 32'(SLOTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_SCAN,
        S_CLEAR,
        S_DONE
    } t_state;

    t_state                r_state, n_state;
    logic [FUNC_W-1:0]     r_func, n_func;
    logic [KEY_W-1:0]      r_key, n_key;
    logic [VALUE_BITS-1:0] r_value, n_value;
    logic [IW-1:0]         r_pos, n_pos;
    logic [IW-1:0]         r_step, n_step;
    logic [IW-1:0]         r_cnt, n_cnt;
    logic                  r_tomb_ok, n_tomb_ok;
    logic [IW-1:0]         r_tomb_at, n_tomb_at;
    logic                  r_init, n_init;
    logic [CW-1:0]         r_used, n_used;
    logic [CW-1:0]         r_tombs, n_tombs;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic [DATA_W-1:0]     r_fval, n_fval;
    logic [KEY_W-1:0]      r_fkey, n_fkey;
    logic [IDX_W-1:0]      r_nxt, n_nxt;

    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [MW-1:0]         wr_data;
    logic [MW-1:0]         rd_data;
    logic [TAG_W-1:0]      rd_tag;
    logic [KEY_W-1:0]      rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic [IW-1:0]         pos_sum;
    logic                  last_slot;
    logic                  is_empty;
    logic                  is_tomb;
    logic                  hit_live;
    logic                  tomb_any;
    logic [IW-1:0]         tomb_addr;
    logic                  at_limit;

    ohtu_slot_mem #(
        .DEPTH (SLOTS),
        .WIDTH (MW)
    ) u_slot_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (n_pos),
        .o_rd_data (rd_data)
    );

    // Split slot word
    assign rd_tag = rd_data[MW-1 -: TAG_W];
    assign rd_key = rd_data[VALUE_BITS +: KEY_W];
    assign rd_val = rd_data[VALUE_BITS-1:0];

    // Shared address adder: triangular step while probing, one otherwise
    assign pos_sum   = r_pos + ((r_state == S_PROBE) ? r_step : IW'(1));
    assign last_slot = (r_pos == {IW{1'b1}});

    // Slot classification
    assign is_empty  = (rd_tag == TAG_EMPTY);
    assign is_tomb   = (rd_tag == TAG_TOMB);
    assign hit_live  = (rd_tag == TAG_LIVE) && (rd_key == r_key);
    assign tomb_any  = r_tomb_ok || is_tomb;
    assign tomb_addr = r_tomb_ok ? r_tomb_at : r_pos;
    assign at_limit  = (32'(r_used) + 32'd1) >= 32'(i_load_limit);

    // Sequencer next state and slot writes
    always_comb begin
        n_state   = r_state;
        n_func    = r_func;
        n_key     = r_key;
        n_value   = r_value;
        n_pos     = r_pos;
        n_step    = r_step;
        n_cnt     = r_cnt;
        n_tomb_ok = r_tomb_ok;
        n_tomb_at = r_tomb_at;
        n_init    = r_init;
        n_used    = r_used;
        n_tombs   = r_tombs;
        n_status  = r_status;
        n_fval    = r_fval;
        n_fkey    = r_fkey;
        n_nxt     = r_nxt;
        wr_en     = 1'b0;
        wr_addr   = r_pos;
        wr_data   = {TAG_EMPTY, r_key, r_value};

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_func    = i_req.func;
                    n_key     = i_req.key;
                    n_value   = VALUE_BITS'(i_req.value);
                    n_status  = ST_MISS;
                    n_fval    = '0;
                    n_fkey    = '0;
                    n_nxt     = '0;
                    n_step    = IW'(1);
                    n_cnt     = '0;
                    n_tomb_ok = 1'b0;
                    case (i_req.func)
                        FUNC_GET, FUNC_SET, FUNC_POP: begin
                            n_pos   = i_req.key[IW-1:0];
                            n_state = S_PROBE;
                        end
                        FUNC_SCAN: begin
                            if (32'(i_req.scan_from) >= SLOTS_W) begin
                                n_nxt   = SLOTS_W[IDX_W-1:0];
                                n_state = S_DONE;
                            end else begin
                                n_pos   = IW'(i_req.scan_from);
                                n_state = S_SCAN;
                            end
                        end
                        FUNC_CLEAR: begin
                            n_pos   = '0;
                            n_state = S_CLEAR;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_PROBE: begin
                if (hit_live) begin
                    n_state  = S_DONE;
                    n_status = ST_HIT;
                    case (r_func)
                        FUNC_GET: begin
                            n_fval = DATA_W'(rd_val);
                        end
                        FUNC_SET: begin
                            wr_en   = 1'b1;
                            wr_data = {TAG_LIVE, r_key, r_value};
                        end
                        FUNC_POP: begin
                            wr_en   = 1'b1;
                            wr_data = {TAG_TOMB, rd_key, rd_val};
                            n_fval  = DATA_W'(rd_val);
                            n_tombs = r_tombs + CW'(1);
                        end
                        default: begin
                        end
                    endcase
                end else if (is_empty || (r_cnt == {IW{1'b1}})) begin
                    // Probe ended without the key
                    n_state = S_DONE;
                    if (r_func == FUNC_SET) begin
                        if (at_limit) begin
                            n_status = ST_FULL;
                        end else if (tomb_any) begin
                            wr_en    = 1'b1;
                            wr_addr  = tomb_addr;
                            wr_data  = {TAG_LIVE, r_key, r_value};
                            n_tombs  = r_tombs - CW'(1);
                            n_status = ST_INSERTED;
                        end else if (is_empty) begin
                            wr_en    = 1'b1;
                            wr_data  = {TAG_LIVE, r_key, r_value};
                            n_used   = r_used + CW'(1);
                            n_status = ST_INSERTED;
                        end else begin
                            n_status = ST_FULL;
                        end
                    end
                end else begin
                    // Remember first tombstone, advance probe
                    if (is_tomb && !r_tomb_ok) begin
                        n_tomb_ok = 1'b1;
                        n_tomb_at = r_pos;
                    end
                    n_pos  = pos_sum;
                    n_step = r_step + IW'(1);
                    n_cnt  = r_cnt + IW'(1);
                end
            end

            S_SCAN: begin
                if (rd_tag == TAG_LIVE) begin
                    n_status = ST_HIT;
                    n_fval   = DATA_W'(rd_val);
                    n_fkey   = rd_key;
                    n_nxt    = IDX_W'({1'b0, r_pos} + CW'(1));
                    n_state  = S_DONE;
                end else if (last_slot) begin
                    n_nxt   = SLOTS_W[IDX_W-1:0];
                    n_state = S_DONE;
                end else begin
                    n_pos = pos_sum;
                end
            end

            S_CLEAR: begin
                wr_en = 1'b1;
                if (last_slot) begin
                    n_used  = '0;
                    n_tombs = '0;
                    if (r_init) begin
                        n_init  = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_status = ST_CLEARED;
                        n_state  = S_DONE;
                    end
                end else begin
                    n_pos = pos_sum;
                end
            end

            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state, counts and result; reset starts the clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_pos     <= '0;
            r_init    <= 1'b1;
            r_used    <= '0;
            r_tombs   <= '0;
            r_tomb_ok <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_init    <= n_init;
            r_used    <= n_used;
            r_tombs   <= n_tombs;
            r_tomb_ok <= n_tomb_ok;
        end
        r_func    <= n_func;
        r_key     <= n_key;
        r_value   <= n_value;
        r_step    <= n_step;
        r_cnt     <= n_cnt;
        r_tomb_at <= n_tomb_at;
        r_status  <= n_status;
        r_fval    <= n_fval;
        r_fkey    <= n_fkey;
        r_nxt     <= n_nxt;
    end

    // Result
    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res.status      = r_status;
    assign o_res.found_value = r_fval;
    assign o_res.found_key   = r_fkey;
    assign o_res.next_scan   = r_nxt;
    assign o_res.live_count  = IDX_W'(r_used - r_tombs);

`ifndef SYNTH
    a_tombs_le_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tombs <= r_used)
        else $error("tombstone count exceeds used count");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(SLOTS))
        else $error("used count exceeds table size");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (r_status == ST_CLEARED)) |-> (r_used == '0 && r_tombs == '0))
        else $error("clear result with nonzero counts");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=> (o_res_valid && $stable(o_res)))
        else $error("pending result changed");
`endif

endmodule

### rtl/open_addressing_hash_table_unit.sv
`timescale 1ns / 1ps
// Get/set/pop read one probed slot per cycle; scan reads slots in order until a live one,
//   and reads none when it starts beyond the table; clear sweeps every slot; undefined
//   codes read no slot.
// Throughput: one request in flight; the next is taken the cycle after its result is queued.
// Reset (synchronous, active low): a sweep over all slots empties every slot, during
//   which o_in_ready is low; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// open_addressing_hash_table_unit
// Hash table keyed by character code with triangular probing, tombstones,
// scan and clear, load-limit register and a registered result port.
// ----------------------------------------------------------------------------
module open_addressing_hash_table_unit import ohtu_pkg::*; #(
    parameter int SLOTS      = DEF_SLOTS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [KEY_W-1:0]    i_key,
    input  logic [DATA_W-1:0]   i_value,
    input  logic [IDX_W-1:0]    i_scan_from,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [DATA_W-1:0]   o_found_value,
    output logic [KEY_W-1:0]    o_found_key,
    output logic [IDX_W-1:0]    o_next_scan,
    output logic [IDX_W-1:0]    o_live_count,
    // load limit write channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [IDX_W-1:0]    i_cfg_data
);

    t_req             req;
    t_result          res;
    logic             eng_idle;
    logic             res_valid;
    logic             res_ready;
    logic [IDX_W-1:0] r_load_limit;
    logic             r_out_valid;
    t_result          r_out;

    assign req.func      = i_func;
    assign req.key       = i_key;
    assign req.value     = i_value;
    assign req.scan_from = i_scan_from;

    ohtu_engine #(
        .SLOTS      (SLOTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_in_valid && o_in_ready),
        .i_req        (req),
        .i_load_limit (r_load_limit),
        .o_idle       (eng_idle),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res)
    );

    assign o_in_ready  = eng_idle;
    assign o_cfg_ready = 1'b1;

    // Load limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_limit <= LOAD_LIMIT_RST;
        end else if (i_cfg_valid) begin
            r_load_limit <= i_cfg_data;
        end
    end

    // Output register: take a result when empty or being drained
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out.status;
    assign o_found_value = r_out.found_value;
    assign o_found_key   = r_out.found_key;
    assign o_next_scan   = r_out.next_scan;
    assign o_live_count  = r_out.live_count;

endmodule

### verif/ohtu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohtu_checker
// Watches the request, result and load-limit channels of the hash table unit.
// Keeps a shadow copy of the table, predicts the result of every accepted
// request and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module ohtu_checker import ohtu_pkg::*; #(
    parameter int SLOTS = DEF_SLOTS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [KEY_W-1:0]    i_key,
    input  logic [DATA_W-1:0]   i_value,
    input  logic [IDX_W-1:0]    i_scan_from,
    // result channel
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [STATUS_W-1:0] i_status,
    input  logic [DATA_W-1:0]   i_found_value,
    input  logic [KEY_W-1:0]    i_found_key,
    input  logic [IDX_W-1:0]    i_next_scan,
    input  logic [IDX_W-1:0]    i_live_count,
    // load limit write channel
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [IDX_W-1:0]    i_cfg_data,
    // status towards the testbench top
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked
);

    // Shadow table
    logic [TAG_W-1:0]  shadow_tag   [SLOTS];
    logic [KEY_W-1:0]  shadow_key   [SLOTS];
    logic [DATA_W-1:0] shadow_value [SLOTS];
    int                used_slots;
    int                tomb_slots;
    int                load_limit;

    // Results predicted but not yet seen on the result channel
    t_result           awaited_results [$];
    t_result           oldest;

    // Walk the triangular probe path of a key; report the live slot holding it,
    // the first tombstone met and the empty slot that ended the walk
    function automatic bit find_key(input logic [KEY_W-1:0] k, output int hit_at,
                                    output int first_tomb, output int end_empty);
        int pos;
        int step;
        int n;
        hit_at     = 0;
        first_tomb = SLOTS;
        end_empty  = SLOTS;
        pos        = int'(k) & (SLOTS - 1);
        step       = 0;
        for (n = 0; n < SLOTS; n++) begin
            if (shadow_tag[pos] == TAG_EMPTY) begin
                end_empty = pos;
                return 1'b0;
            end
            if (shadow_tag[pos] == TAG_TOMB) begin
                if (first_tomb == SLOTS) first_tomb = pos;
            end else if (shadow_key[pos] == k) begin
                hit_at = pos;
                return 1'b1;
            end
            step++;
            pos = (pos + step) & (SLOTS - 1);
        end
        return 1'b0;
    endfunction

    // Apply one request to the shadow table and return the result it must give
    function automatic t_result apply_request(input logic [FUNC_W-1:0] f,
                                              input logic [KEY_W-1:0] k,
                                              input logic [DATA_W-1:0] v,
                                              input logic [IDX_W-1:0] scan_start);
        t_result r;
        int      at;
        int      tomb;
        int      empty;
        int      i;
        r        = '0;
        r.status = ST_MISS;
        case (f)
            FUNC_GET: begin
                if (find_key(k, at, tomb, empty)) begin
                    r.status      = ST_HIT;
                    r.found_value = shadow_value[at];
                end
            end
            FUNC_SET: begin
                if (find_key(k, at, tomb, empty)) begin
                    shadow_value[at] = v;
                    r.status         = ST_HIT;
                end else if (used_slots + 1 >= load_limit) begin
                    r.status = ST_FULL;
                end else if (tomb < SLOTS) begin
                    shadow_tag[tomb]   = TAG_LIVE;
                    shadow_key[tomb]   = k;
                    shadow_value[tomb] = v;
                    tomb_slots--;
                    r.status = ST_INSERTED;
                end else if (empty < SLOTS) begin
                    shadow_tag[empty]   = TAG_LIVE;
                    shadow_key[empty]   = k;
                    shadow_value[empty] = v;
                    used_slots++;
                    r.status = ST_INSERTED;
                end else begin
                    r.status = ST_FULL;
                end
            end
            FUNC_POP: begin
                if (find_key(k, at, tomb, empty)) begin
                    r.found_value  = shadow_value[at];
                    shadow_tag[at] = TAG_TOMB;
                    tomb_slots++;
                    r.status = ST_HIT;
                end
            end
            FUNC_SCAN: begin
                r.next_scan = IDX_W'(SLOTS);
                for (i = int'(scan_start); i < SLOTS; i++) begin
                    if (shadow_tag[i] == TAG_LIVE) begin
                        r.status      = ST_HIT;
                        r.found_value = shadow_value[i];
                        r.found_key   = shadow_key[i];
                        r.next_scan   = IDX_W'(i + 1);
                        break;
                    end
                end
            end
            FUNC_CLEAR: begin
                for (i = 0; i < SLOTS; i++) shadow_tag[i] = TAG_EMPTY;
                used_slots = 0;
                tomb_slots = 0;
                r.status   = ST_CLEARED;
            end
            default: begin
            end
        endcase
        r.live_count = IDX_W'(used_slots - tomb_slots);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] seen);
        if (want !== seen) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, seen);
            o_fail_count++;
        end
    endtask

    // Track the three channels at every rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                shadow_tag[i]   = TAG_EMPTY;
                shadow_key[i]   = '0;
                shadow_value[i] = '0;
            end
            used_slots   = 0;
            tomb_slots   = 0;
            load_limit   = int'(LOAD_LIMIT_RST);
            o_fail_count = 0;
            o_checked    = 0;
            awaited_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) load_limit = int'(i_cfg_data);
            // compare the result against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result with status %0d arrived with no request outstanding",
                           i_status);
                    o_fail_count++;
                end else begin
                    oldest = awaited_results.pop_front();
                    check_field("status", DATA_W'(oldest.status), DATA_W'(i_status));
                    check_field("found_value", oldest.found_value, i_found_value);
                    check_field("found_key", DATA_W'(oldest.found_key),
                                DATA_W'(i_found_key));
                    check_field("next_scan", DATA_W'(oldest.next_scan),
                                DATA_W'(i_next_scan));
                    check_field("live_count", DATA_W'(oldest.live_count),
                                DATA_W'(i_live_count));
                    o_checked++;
                end
            end
            // predict the accepted request
            if (i_in_valid && i_in_ready)
                awaited_results.push_back(apply_request(i_func, i_key, i_value,
                                                        i_scan_from));
        end
        o_pending = awaited_results.size();
    end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the open-addressing hash table unit: a directed opening over
// hits, misses, tombstones, scans, clear and full, then random request mixes
// over colliding key sets under several load limits, with random stalls on
// both channels. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    import ohtu_pkg::*;

    localparam int SLOTS          = DEF_SLOTS;
    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int POOL           = 45;

    localparam logic [KEY_W-1:0] KEY_MAX = 21'h10FFFF;

    // Function codes the block does not define
    localparam logic [FUNC_W-1:0] FUNC_RSVD_FIRST = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_RSVD_MID   = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_RSVD_LAST  = 3'd7;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                req_valid;
    logic                in_ready;
    logic [FUNC_W-1:0]   req_func;
    logic [KEY_W-1:0]    req_key;
    logic [DATA_W-1:0]   req_value;
    logic [IDX_W-1:0]    req_scan_from;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [STATUS_W-1:0] res_status;
    logic [DATA_W-1:0]   res_found_value;
    logic [KEY_W-1:0]    res_found_key;
    logic [IDX_W-1:0]    res_next_scan;
    logic [IDX_W-1:0]    res_live_count;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_data;

    int fail_count;
    int pending;
    int checked;
    int stall_cycles = 0;
    int func_count [8];
    int cfg_writes   = 0;
    bit calm         = 1'b0;
    int rx_hold      = 0;
    int rx_gap;

    always #(CLK_HALF) clk = ~clk;

    open_addressing_hash_table_unit u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (req_valid),
        .o_in_ready    (in_ready),
        .i_func        (req_func),
        .i_key         (req_key),
        .i_value       (req_value),
        .i_scan_from   (req_scan_from),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_status      (res_status),
        .o_found_value (res_found_value),
        .o_found_key   (res_found_key),
        .o_next_scan   (res_next_scan),
        .o_live_count  (res_live_count),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data)
    );

    ohtu_checker #(.SLOTS(SLOTS)) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (req_valid),
        .i_in_ready    (in_ready),
        .i_func        (req_func),
        .i_key         (req_key),
        .i_value       (req_value),
        .i_scan_from   (req_scan_from),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_status      (res_status),
        .i_found_value (res_found_value),
        .i_found_key   (res_found_key),
        .i_next_scan   (res_next_scan),
        .i_live_count  (res_live_count),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    // Mostly no gap, some short ones, a few long ones; none in calm stretches
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Stall the result channel at random
    always @(negedge clk) begin
        if (rx_hold > 0) begin
            rx_hold   <= rx_hold - 1;
            out_ready <= 1'b0;
        end else begin
            rx_gap = pick_gap();
            if (rx_gap > 0) begin
                rx_hold   <= rx_gap - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Count cycles in which no channel moves anything
    always @(posedge clk) begin
        if ((req_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pending);
        $display("CHECKS FAILED");
        $finish;
    end

    // Offer one request after a random gap and hold it until accepted
    task automatic send_request(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                                input logic [DATA_W-1:0] v,
                                input logic [IDX_W-1:0] scan_start);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid     <= 1'b1;
        req_func      <= f;
        req_key       <= k;
        req_value     <= v;
        req_scan_from <= scan_start;
        do @(posedge clk); while (!in_ready);
        func_count[f]++;
    endtask

    // Drop the request valid and hold until every predicted result has come
    task automatic settle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_load_limit(input logic [IDX_W-1:0] limit);
        settle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= limit;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // Random mix over a key set where most keys share one home slot
    task automatic random_phase(input int count, input bit pause_midway);
        logic [KEY_W-1:0]  key_pool [POOL];
        logic [FUNC_W-1:0] f;
        logic [KEY_W-1:0]  k;
        logic [IDX_W-1:0]  scan_start;
        int                home;
        int                r;
        int                i;
        home = $urandom_range(0, SLOTS - 1);
        for (i = 0; i < POOL; i++) begin
            if (i % 3 == 0)
                key_pool[i] = KEY_W'($urandom_range(0, KEY_MAX));
            else
                key_pool[i] = KEY_W'(home + SLOTS *
                                     $urandom_range(0, (KEY_MAX - home) / SLOTS));
        end
        for (i = 0; i < count; i++) begin
            if (i % 25 == 0) calm = ($urandom_range(0, 3) == 0);
            if (pause_midway && i == count / 2) settle();
            r = $urandom_range(0, 199);
            if (r < 70)       f = FUNC_SET;
            else if (r < 120) f = FUNC_GET;
            else if (r < 160) f = FUNC_POP;
            else if (r < 191) f = FUNC_SCAN;
            else if (r < 195) f = FUNC_CLEAR;
            else f = FUNC_W'($urandom_range(int'(FUNC_RSVD_FIRST), int'(FUNC_RSVD_LAST)));
            if ($urandom_range(0, 9) == 0) k = KEY_W'($urandom_range(0, KEY_MAX));
            else                           k = key_pool[$urandom_range(0, POOL - 1)];
            r = $urandom_range(0, 9);
            if (r < 2)       scan_start = '0;
            else if (r == 2) scan_start = IDX_W'(SLOTS);
            else if (r == 3) scan_start = IDX_W'(SLOTS - 1);
            else             scan_start = IDX_W'($urandom_range(0, SLOTS));
            send_request(f, k, $urandom, scan_start);
        end
    endtask

    initial begin
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req_func      = FUNC_GET;
        req_key       = '0;
        req_value     = '0;
        req_scan_from = '0;
        cfg_valid     = 1'b0;
        cfg_data      = LOAD_LIMIT_RST;
        foreach (func_count[i]) func_count[i] = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening under the reset load limit
        send_request(FUNC_GET, '0, '0, '0);                     // miss on an empty table
        send_request(FUNC_SCAN, '0, '0, '0);                    // scan of an empty table
        send_request(FUNC_SET, '0, '0, '0);
        send_request(FUNC_SET, KEY_MAX, '1, '0);
        send_request(FUNC_SET, 21'h3FF, 32'h5A5A5A5A, '0);      // collides with the key above
        send_request(FUNC_GET, 21'h3FF, '0, '0);
        send_request(FUNC_SET, KEY_MAX, 32'h12345678, '0);      // replace in place
        send_request(FUNC_POP, KEY_MAX, '0, '0);                // leaves a tombstone
        send_request(FUNC_POP, KEY_MAX, '0, '0);
        send_request(FUNC_GET, 21'h3FF, '0, '0);                // probe past the tombstone
        send_request(FUNC_SET, 21'h7FF, 32'hA5A5A5A5, '0);      // reuse the tombstone
        send_request(FUNC_SCAN, '0, '0, '0);
        send_request(FUNC_SCAN, '0, '0, 11'd1);
        send_request(FUNC_SCAN, '0, '0, IDX_W'(SLOTS - 1));
        send_request(FUNC_SCAN, '0, '0, IDX_W'(SLOTS));         // start beyond the table
        send_request(FUNC_RSVD_FIRST, KEY_MAX, '1, IDX_W'(SLOTS));
        send_request(FUNC_RSVD_MID, 21'h3FF, 32'h0F0F0F0F, '0);
        send_request(FUNC_RSVD_LAST, 21'h7FF, '1, 11'd5);
        send_request(FUNC_CLEAR, '0, '0, '0);
        send_request(FUNC_GET, '0, '0, '0);

        // Smallest limits: every new key full, then room for exactly one
        write_load_limit(11'd1);
        send_request(FUNC_SET, 21'h155, 32'h11111111, '0);
        send_request(FUNC_GET, 21'h155, '0, '0);
        write_load_limit(11'd2);
        send_request(FUNC_SET, 21'h155, 32'h22222222, '0);
        send_request(FUNC_SET, 21'h2AA, 32'h33333333, '0);
        send_request(FUNC_SET, 21'h155, 32'h44444444, '0);      // present key is never full

        // Random phases over a spread of load limits
        write_load_limit(IDX_W'(SLOTS));
        random_phase(150, 1'b1);
        write_load_limit(IDX_W'($urandom_range(3, 64)));
        random_phase(130, 1'b0);
        write_load_limit(11'd1);
        random_phase(40, 1'b0);
        write_load_limit(LOAD_LIMIT_RST);
        random_phase(130, 1'b0);
        write_load_limit(IDX_W'(SLOTS - 1));
        random_phase(100, 1'b0);

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Summary: get %0d, set %0d, pop %0d, scan %0d, clear %0d, undefined codes %0d",
                 func_count[FUNC_GET], func_count[FUNC_SET], func_count[FUNC_POP],
                 func_count[FUNC_SCAN], func_count[FUNC_CLEAR],
                 func_count[FUNC_RSVD_FIRST] + func_count[FUNC_RSVD_MID] +
                 func_count[FUNC_RSVD_LAST]);
        $display("Summary: %0d results compared over %0d load-limit settings",
                 checked, cfg_writes);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/ohtu_pkg.sv
rtl/ohtu_slot_mem.sv
rtl/ohtu_engine.sv
rtl/open_addressing_hash_table_unit.sv
verif/ohtu_checker.sv
verif/tb_top.sv
